// File: hw/rtl/mcpf_pkg.sv
// Package for the multi-channel pipe FIFO: word types, status and command codes.
// Used by the front end, the back end and the top level; depends on nothing.
package mcpf_pkg;

    // Handles are given out from this window of values.
    localparam logic [7:0] HANDLE_FIRST = 8'd100;
    localparam int         HANDLE_SPAN  = 100;
    localparam int         HIDX_W       = 7;

    // Channel index field of a command, wide enough for up to 64 channels.
    localparam int         CHAN_IDX_W   = 6;

    typedef enum logic [1:0] {
        ACT_CREATE = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLOSE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EOD      = 3'd1,
        ST_NOTPIPE  = 3'd2,
        ST_BLOCK    = 3'd3,
        ST_BROKEN   = 3'd4,
        ST_NOSLOT   = 3'd5,
        ST_NOHANDLE = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CMD_REPORT = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd_op;

    typedef enum logic {
        B_IDLE  = 1'b0,
        B_BURST = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] handle;
        logic [7:0] data_in;
        logic [6:0] length;
    } t_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] data_out;
        logic [7:0] read_handle;
        logic [7:0] write_handle;
        logic       last;
    } t_result;

    // Classified word passed from the front to the back.
    typedef struct packed {
        t_cmd_op               op;
        t_status               status;
        logic [CHAN_IDX_W-1:0] chan;
        logic [7:0]            rh;
        logic [7:0]            wh;
        logic [7:0]            data;
        logic [6:0]            len;
        logic                  wopen;
    } t_cmd;

endpackage

// File: hw/rtl/mcpf_queue.sv
// Small first-word-fall-through queue used between the stages of the pipe FIFO.
// Depends on nothing but its type parameter.
module mcpf_queue #(
    parameter type t_word = logic [7:0],
    parameter int  DEPTH  = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  t_word                      i_wdata,
    input  logic                       i_pop,
    output logic                       o_empty,
    output t_word                      o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    t_word           r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp, n_wp, n_rp;
    logic [CNW-1:0]  r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CNW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer wrap at the queue depth.
    always_comb begin
        n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
    end

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= n_wp;
            end
            if (do_pop) begin
                r_rp <= n_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNW'(1);
            end else if (!do_push && do_pop) begin
                r_cnt <= r_cnt - CNW'(1);
            end
        end
    end
endmodule

// File: hw/rtl/mcpf_front.sv
// Front end of the pipe FIFO: takes each word, resolves handles against the end table
// and hands a classified command on. Depends on mcpf_pkg.
module mcpf_front #(
    parameter int CHANNELS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  mcpf_pkg::t_item i_item,
    output logic            o_cmd_push,
    input  logic            i_cmd_full,
    output mcpf_pkg::t_cmd  o_cmd
);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                                 r_valid;
    mcpf_pkg::t_item                      r_item;
    logic [7:0]                           r_rh [CHANNELS];
    logic [7:0]                           r_wh [CHANNELS];
    logic [CHANNELS-1:0]                  r_ro, r_wo;
    logic [mcpf_pkg::HANDLE_SPAN-1:0]     r_used;

    logic                                 go;
    logic                                 hit, hit_rd;
    logic [CW-1:0]                        hit_ch;
    logic                                 slot_ok;
    logic [CW-1:0]                        slot;
    logic                                 have1, have2;
    logic [mcpf_pkg::HIDX_W-1:0]          f1, f2;
    logic [7:0]                           hoff;
    mcpf_pkg::t_cmd                       cmd;

    assign full       = r_valid;
    assign go         = r_valid && !i_cmd_full;
    assign o_cmd_push = go;
    assign o_cmd      = cmd;
    assign hoff       = r_item.handle - mcpf_pkg::HANDLE_FIRST;

    // Handle lookup: lowest channel wins, read end before write end.
    always_comb begin
        hit    = 1'b0;
        hit_rd = 1'b0;
        hit_ch = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (r_wo[c] && (r_wh[c] == r_item.handle)) begin
                hit    = 1'b1;
                hit_rd = 1'b0;
                hit_ch = CW'(c);
            end
            if (r_ro[c] && (r_rh[c] == r_item.handle)) begin
                hit    = 1'b1;
                hit_rd = 1'b1;
                hit_ch = CW'(c);
            end
        end
    end

    // Lowest channel with both ends closed.
    always_comb begin
        slot_ok = 1'b0;
        slot    = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (!r_ro[c] && !r_wo[c]) begin
                slot_ok = 1'b1;
                slot    = CW'(c);
            end
        end
    end

    // The two lowest handles that no open end holds.
    always_comb begin
        have1 = 1'b0;
        have2 = 1'b0;
        f1    = '0;
        f2    = '0;
        for (int i = mcpf_pkg::HANDLE_SPAN - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                have2 = have1;
                have1 = 1'b1;
                f2    = f1;
                f1    = mcpf_pkg::HIDX_W'(i);
            end
        end
    end

    // Classification of the held word.
    always_comb begin
        cmd        = '0;
        cmd.op     = mcpf_pkg::CMD_REPORT;
        cmd.status = mcpf_pkg::ST_OK;
        cmd.data   = r_item.data_in;
        cmd.len    = r_item.length;
        case (mcpf_pkg::t_action'(r_item.action))
            mcpf_pkg::ACT_CREATE: begin
                if (!slot_ok) begin
                    cmd.status = mcpf_pkg::ST_NOSLOT;
                end else if (!have2) begin
                    cmd.status = mcpf_pkg::ST_NOHANDLE;
                end else begin
                    cmd.op   = mcpf_pkg::CMD_CREATE;
                    cmd.chan = mcpf_pkg::CHAN_IDX_W'(slot);
                    cmd.rh   = mcpf_pkg::HANDLE_FIRST + 8'(f1);
                    cmd.wh   = mcpf_pkg::HANDLE_FIRST + 8'(f2);
                end
            end
            mcpf_pkg::ACT_WRITE: begin
                if (!hit || hit_rd) begin
                    cmd.status = mcpf_pkg::ST_NOTPIPE;
                end else if (!r_ro[hit_ch]) begin
                    cmd.status = mcpf_pkg::ST_BROKEN;
                end else begin
                    cmd.op   = mcpf_pkg::CMD_WRITE;
                    cmd.chan = mcpf_pkg::CHAN_IDX_W'(hit_ch);
                end
            end
            mcpf_pkg::ACT_READ: begin
                if (!hit || !hit_rd) begin
                    cmd.status = mcpf_pkg::ST_NOTPIPE;
                end else begin
                    cmd.op    = mcpf_pkg::CMD_READ;
                    cmd.chan  = mcpf_pkg::CHAN_IDX_W'(hit_ch);
                    cmd.wopen = r_wo[hit_ch];
                end
            end
            mcpf_pkg::ACT_CLOSE: begin
                if (!hit) begin
                    cmd.status = mcpf_pkg::ST_NOTPIPE;
                end
            end
            default: begin
                cmd.status = mcpf_pkg::ST_NOTPIPE;
            end
        endcase
    end

    // Input holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (push && !r_valid) begin
            r_valid <= 1'b1;
        end else if (go) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && !r_valid) begin
            r_item <= i_item;
        end
    end

    // End table: handles, open flags and the in-use map of handles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ro   <= '0;
            r_wo   <= '0;
            r_used <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_rh[c] <= '0;
                r_wh[c] <= '0;
            end
        end else if (go) begin
            if (cmd.op == mcpf_pkg::CMD_CREATE) begin
                r_ro[slot]   <= 1'b1;
                r_wo[slot]   <= 1'b1;
                r_rh[slot]   <= cmd.rh;
                r_wh[slot]   <= cmd.wh;
                r_used[f1]   <= 1'b1;
                r_used[f2]   <= 1'b1;
            end else if ((mcpf_pkg::t_action'(r_item.action) == mcpf_pkg::ACT_CLOSE)
                         && hit) begin
                if (hit_rd) begin
                    r_ro[hit_ch] <= 1'b0;
                end else begin
                    r_wo[hit_ch] <= 1'b0;
                end
                r_used[hoff[mcpf_pkg::HIDX_W-1:0]] <= 1'b0;
            end
        end
    end
endmodule

// File: hw/rtl/mcpf_back.sv
// Back end of the pipe FIFO: channel pointers, fill levels and the byte memory.
// Carries out classified commands and streams read bursts. Depends on mcpf_pkg.
module mcpf_back #(
    parameter int CHANNELS   = 16,
    parameter int FIFO_BYTES = 4096,
    parameter int MAX_BURST  = 64,
    parameter int OUT_DEPTH  = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_empty,
    input  mcpf_pkg::t_cmd                 i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_res_push,
    output mcpf_pkg::t_result              o_res,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count
);
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW  = $clog2(FIFO_BYTES);
    localparam int FW  = $clog2(FIFO_BYTES + 1);
    localparam int AW  = $clog2(CHANNELS * FIFO_BYTES);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    mcpf_pkg::t_back_state r_state, n_state;
    logic [7:0]            r_mem [CHANNELS * FIFO_BYTES];
    logic [PW-1:0]         r_head [CHANNELS];
    logic [PW-1:0]         r_tail [CHANNELS];
    logic [FW-1:0]         r_fill [CHANNELS];
    logic [CW-1:0]         r_chan;
    logic [6:0]            r_left;
    logic                  r_pend, r_pend_last;
    logic [7:0]            r_q;

    logic [CW-1:0]         ch;
    logic [FW-1:0]         fill_c;
    logic [6:0]            len1, nburst;
    logic                  take, issue;
    logic [PW-1:0]         head_b, head_nx, tail_nx;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic                  wr_en;

    assign o_cmd_pop = take;
    assign ch      = i_cmd.chan[CW-1:0];
    assign fill_c  = r_fill[ch];
    assign head_b  = r_head[r_chan];
    assign head_nx = (head_b == PW'(FIFO_BYTES - 1)) ? '0 : head_b + PW'(1);
    assign tail_nx = (r_tail[ch] == PW'(FIFO_BYTES - 1)) ? '0 : r_tail[ch] + PW'(1);
    assign rd_addr = AW'(AW'(r_chan) * AW'(FIFO_BYTES)) + AW'(head_b);
    assign wr_addr = AW'(AW'(ch) * AW'(FIFO_BYTES)) + AW'(r_tail[ch]);

    // Burst length: at least one byte, at most the burst limit and the fill level.
    always_comb begin
        len1 = (i_cmd.len == '0) ? 7'd1 : i_cmd.len;
        if (len1 > 7'(MAX_BURST)) begin
            len1 = 7'(MAX_BURST);
        end
        nburst = (17'(len1) > 17'(fill_c)) ? 7'(fill_c) : len1;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcpf_pkg::B_IDLE: begin
                if (take && (i_cmd.op == mcpf_pkg::CMD_READ) && (fill_c != '0)) begin
                    n_state = mcpf_pkg::B_BURST;
                end
            end
            mcpf_pkg::B_BURST: begin
                if (issue && (r_left == 7'd1)) begin
                    n_state = mcpf_pkg::B_IDLE;
                end
            end
            default: n_state = mcpf_pkg::B_IDLE;
        endcase
    end

    // Outputs: command pop, result push, memory access.
    always_comb begin
        take       = 1'b0;
        issue      = 1'b0;
        wr_en      = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.last = 1'b1;
        case (r_state)
            mcpf_pkg::B_IDLE: begin
                if (r_pend) begin
                    o_res_push    = 1'b1;
                    o_res.data_out = r_q;
                    o_res.last    = r_pend_last;
                end else if (!i_cmd_empty && (i_out_count < OCW'(OUT_DEPTH))) begin
                    take = 1'b1;
                    case (i_cmd.op)
                        mcpf_pkg::CMD_REPORT: begin
                            o_res_push   = 1'b1;
                            o_res.status = i_cmd.status;
                        end
                        mcpf_pkg::CMD_CREATE: begin
                            o_res_push         = 1'b1;
                            o_res.read_handle  = i_cmd.rh;
                            o_res.write_handle = i_cmd.wh;
                        end
                        mcpf_pkg::CMD_WRITE: begin
                            o_res_push = 1'b1;
                            if (fill_c == FW'(FIFO_BYTES)) begin
                                o_res.status = mcpf_pkg::ST_BLOCK;
                            end else begin
                                wr_en = 1'b1;
                            end
                        end
                        mcpf_pkg::CMD_READ: begin
                            if (fill_c == '0) begin
                                o_res_push   = 1'b1;
                                o_res.status = i_cmd.wopen ? mcpf_pkg::ST_BLOCK
                                                           : mcpf_pkg::ST_EOD;
                            end
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            mcpf_pkg::B_BURST: begin
                if (r_pend) begin
                    o_res_push     = 1'b1;
                    o_res.data_out = r_q;
                    o_res.last     = r_pend_last;
                end
                issue = (32'(i_out_count) + 32'(r_pend) + 32'd1) <= OUT_DEPTH;
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    // Byte memory, one write and one registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.data;
        end
        if (issue) begin
            r_q <= r_mem[rd_addr];
        end
    end

    // Sequencer, burst counter and channel pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mcpf_pkg::B_IDLE;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_left      <= '0;
            r_chan      <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_fill[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pend      <= issue;
            r_pend_last <= issue && (r_left == 7'd1);
            if (take) begin
                case (i_cmd.op)
                    mcpf_pkg::CMD_CREATE: begin
                        r_head[ch] <= '0;
                        r_tail[ch] <= '0;
                        r_fill[ch] <= '0;
                    end
                    mcpf_pkg::CMD_WRITE: begin
                        if (wr_en) begin
                            r_tail[ch] <= tail_nx;
                            r_fill[ch] <= fill_c + FW'(1);
                        end
                    end
                    mcpf_pkg::CMD_READ: begin
                        if (fill_c != '0) begin
                            r_fill[ch] <= fill_c - FW'(nburst);
                            r_left     <= nburst;
                            r_chan     <= ch;
                        end
                    end
                    default: begin
                        r_left <= r_left;
                    end
                endcase
            end
            if (issue) begin
                r_head[r_chan] <= head_nx;
                r_left         <= r_left - 7'd1;
            end
        end
    end

    // A burst always has bytes left while it runs.
    a_burst_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mcpf_pkg::B_BURST) |-> (r_left != '0))
        else $error("burst running with no bytes left");

    // Never push a result into a full output queue.
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (i_out_count < OCW'(OUT_DEPTH)))
        else $error("result pushed into full output queue");

    // A fetched byte is delivered in the next cycle.
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> o_res_push)
        else $error("fetched byte not delivered");

    // No command is taken while a burst or a fetched byte is in flight.
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ((r_state == mcpf_pkg::B_IDLE) && !r_pend))
        else $error("command taken during a burst");
endmodule

// File: hw/rtl/multi_channel_pipe_fifo_unit.sv
// Top level of the multi-channel pipe FIFO: front end, command queue, back end and
// result queue. Depends on mcpf_pkg, mcpf_queue, mcpf_front and mcpf_back.
//
//  Channel  | Direction | Handshake        | Word
//  ---------+-----------+------------------+--------------------
//  item     | in        | push / full      | mcpf_pkg::t_item
//  result   | out       | empty / pop      | mcpf_pkg::t_result
//
// A word is held and resolved in the front end's register, so the input takes no new word
// until the held one has been handed on. Create, write, close and failed operations show
// their result after the front end's register, the command queue and the result queue; a
// read streams its bytes one byte per cycle, while the result queue has room, from the single
// read port of the byte memory, and keeps the back end busy until its last byte is passed to
// the result queue. Reset is synchronous and active low; it closes every end and clears every
// pointer. A full result queue stalls the back end and then, through the command queue, the front end.
module multi_channel_pipe_fifo_unit #(
    parameter int CHANNELS   = 16,
    parameter int FIFO_BYTES = 4096,
    parameter int MAX_BURST  = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  mcpf_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output mcpf_pkg::t_result o_result
);
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    logic                           cmd_push, cmd_full, cmd_pop, cmd_empty;
    mcpf_pkg::t_cmd                 cmd_in, cmd_out;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
    logic                           res_push, res_full;
    mcpf_pkg::t_result              res_in;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    mcpf_front #(.CHANNELS(CHANNELS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_cmd_push (cmd_push),
        .i_cmd_full (cmd_full),
        .o_cmd      (cmd_in)
    );

    mcpf_queue #(.t_word(mcpf_pkg::t_cmd), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .o_full  (cmd_full),
        .i_wdata (cmd_in),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_rdata (cmd_out),
        .o_count (cmd_count)
    );

    mcpf_back #(
        .CHANNELS   (CHANNELS),
        .FIFO_BYTES (FIFO_BYTES),
        .MAX_BURST  (MAX_BURST),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_out_count (out_count)
    );

    mcpf_queue #(.t_word(mcpf_pkg::t_result), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_full  (res_full),
        .i_wdata (res_in),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (o_result),
        .o_count (out_count)
    );

    // The command queue never overflows: the front end waits on its full flag.
    a_cmd_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !cmd_full)
        else $error("command queue overflow");

    // The back end never pushes into a full result queue.
    a_res_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result queue overflow");

    // A command is popped only when one is waiting.
    a_cmd_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> (cmd_count != '0))
        else $error("command popped from empty queue");
endmodule

// File: tb/mcpf_checker.sv
`timescale 1ns / 100ps
// Checker for the multi-channel pipe FIFO: watches the item and result channels,
// predicts every result word and compares it. Depends on mcpf_pkg.
module mcpf_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  mcpf_pkg::t_item   i_item,
    input  logic              i_empty,
    input  logic              i_pop,
    input  mcpf_pkg::t_result i_result,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int NCHAN = 16;
    localparam int DEPTH = 4096;
    localparam int BURST = 64;
    localparam int HANDLE_LIMIT = 200;

    // Shadow copy of the channel state.
    logic [7:0]  pipe_bytes [0:NCHAN*DEPTH-1];
    int          rd_pos [NCHAN];
    int          wr_pos [NCHAN];
    int          level [NCHAN];
    logic [7:0]  rd_handle [NCHAN];
    logic [7:0]  wr_handle [NCHAN];
    bit          rd_open [NCHAN];
    bit          wr_open [NCHAN];

    mcpf_pkg::t_result expected_words [$];
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // Finds the channel whose open end carries handle h; -1 when none does.
    function automatic int find_end(input logic [7:0] h, output bit is_rd);
        is_rd = 0;
        for (int c = 0; c < NCHAN; c++) begin
            if (rd_open[c] && rd_handle[c] == h) begin
                is_rd = 1;
                return c;
            end
            if (wr_open[c] && wr_handle[c] == h) return c;
        end
        return -1;
    endfunction

    function automatic mcpf_pkg::t_result status_word(input mcpf_pkg::t_status st);
        mcpf_pkg::t_result r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    // Works out the result words of one accepted item and updates the shadow state.
    task automatic predict_pipe_op(input mcpf_pkg::t_item it);
        int      c, slot, found, n;
        bit      is_rd;
        logic [7:0] new_rd, new_wr;
        mcpf_pkg::t_result r;
        slot = -1;
        found = 0;
        new_rd = '0;
        new_wr = '0;
        case (mcpf_pkg::t_action'(it.action))
            mcpf_pkg::ACT_CREATE: begin
                for (int k = 0; k < NCHAN; k++)
                    if (slot < 0 && !rd_open[k] && !wr_open[k]) slot = k;
                if (slot < 0) begin
                    expected_words.push_back(status_word(mcpf_pkg::ST_NOSLOT));
                end else begin
                    for (int v = mcpf_pkg::HANDLE_FIRST; v < HANDLE_LIMIT && found < 2; v++) begin
                        if (find_end(v[7:0], is_rd) >= 0) continue;
                        if (found == 0) new_rd = v[7:0];
                        else new_wr = v[7:0];
                        found++;
                    end
                    if (found < 2) begin
                        expected_words.push_back(status_word(mcpf_pkg::ST_NOHANDLE));
                    end else begin
                        rd_pos[slot] = 0;
                        wr_pos[slot] = 0;
                        level[slot] = 0;
                        rd_handle[slot] = new_rd;
                        wr_handle[slot] = new_wr;
                        rd_open[slot] = 1;
                        wr_open[slot] = 1;
                        r = status_word(mcpf_pkg::ST_OK);
                        r.read_handle = new_rd;
                        r.write_handle = new_wr;
                        expected_words.push_back(r);
                    end
                end
            end
            mcpf_pkg::ACT_WRITE: begin
                c = find_end(it.handle, is_rd);
                if (c < 0 || is_rd)
                    expected_words.push_back(status_word(mcpf_pkg::ST_NOTPIPE));
                else if (!rd_open[c])
                    expected_words.push_back(status_word(mcpf_pkg::ST_BROKEN));
                else if (level[c] >= DEPTH)
                    expected_words.push_back(status_word(mcpf_pkg::ST_BLOCK));
                else begin
                    pipe_bytes[c*DEPTH + wr_pos[c]] = it.data_in;
                    wr_pos[c] = (wr_pos[c] + 1 >= DEPTH) ? 0 : wr_pos[c] + 1;
                    level[c]++;
                    expected_words.push_back(status_word(mcpf_pkg::ST_OK));
                end
            end
            mcpf_pkg::ACT_READ: begin
                c = find_end(it.handle, is_rd);
                if (c < 0 || !is_rd) begin
                    expected_words.push_back(status_word(mcpf_pkg::ST_NOTPIPE));
                end else if (level[c] == 0) begin
                    expected_words.push_back(status_word(wr_open[c] ? mcpf_pkg::ST_BLOCK
                                                                    : mcpf_pkg::ST_EOD));
                end else begin
                    n = it.length;
                    if (n == 0) n = 1;
                    if (n > BURST) n = BURST;
                    if (n > level[c]) n = level[c];
                    for (int i = 0; i < n; i++) begin
                        r = '0;
                        r.status = mcpf_pkg::ST_OK;
                        r.data_out = pipe_bytes[c*DEPTH + rd_pos[c]];
                        r.last = (i + 1 == n);
                        rd_pos[c] = (rd_pos[c] + 1 >= DEPTH) ? 0 : rd_pos[c] + 1;
                        expected_words.push_back(r);
                    end
                    level[c] -= n;
                end
            end
            default: begin
                c = find_end(it.handle, is_rd);
                if (c < 0) begin
                    expected_words.push_back(status_word(mcpf_pkg::ST_NOTPIPE));
                end else begin
                    if (is_rd) rd_open[c] = 0;
                    else wr_open[c] = 0;
                    expected_words.push_back(status_word(mcpf_pkg::ST_OK));
                end
            end
        endcase
    endtask

    // Results are compared before the item of the same edge is predicted.
    always @(posedge i_clk) begin
        mcpf_pkg::t_result want;
        if (!i_rst_n) begin
            for (int c = 0; c < NCHAN; c++) begin
                rd_pos[c] = 0;
                wr_pos[c] = 0;
                level[c] = 0;
                rd_handle[c] = '0;
                wr_handle[c] = '0;
                rd_open[c] = 0;
                wr_open[c] = 0;
            end
        end else begin
            if (!i_empty && i_pop) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected result word, status", i_result.status, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (i_result.status !== want.status)
                        report_mismatch("status", i_result.status, want.status);
                    if (i_result.data_out !== want.data_out)
                        report_mismatch("data_out", i_result.data_out, want.data_out);
                    if (i_result.read_handle !== want.read_handle)
                        report_mismatch("read_handle", i_result.read_handle,
                                        want.read_handle);
                    if (i_result.write_handle !== want.write_handle)
                        report_mismatch("write_handle", i_result.write_handle,
                                        want.write_handle);
                    if (i_result.last !== want.last)
                        report_mismatch("last", i_result.last, want.last);
                end
            end
            if (i_push && !i_full) predict_pipe_op(i_item);
        end
        o_pending = expected_words.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the pipe FIFO testbench: clock, reset, item and result drivers and the verdict.
// Depends on mcpf_pkg, mcpf_checker and multi_channel_pipe_fifo_unit.
module testbench;

    localparam int CYCLE_LIMIT = 20000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    mcpf_pkg::t_item   i_item;
    logic              empty;
    logic              pop;
    mcpf_pkg::t_result o_result;
    int                fail_count;
    int                pending;
    int                cycles = 0;
    bit                no_gaps = 0;
    bit                hold_results = 0;

    multi_channel_pipe_fifo_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    mcpf_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_item      (i_item),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (no_gaps || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    // Result side: a random wait before each word, and one long hold-off on request.
    initial begin
        int gap;
        pop = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = draw_gap();
            if (hold_results) begin
                pop <= 0;
                repeat (400) @(negedge i_clk);
                hold_results = 0;
            end else if (gap > 0) begin
                pop <= 0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    // Offers one item word and waits until it is taken.
    task automatic send_op(input mcpf_pkg::t_action act, input int h, input int d,
                           input int len);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1;
        i_item <= '{action: act, handle: h[7:0], data_in: d[7:0], length: len[6:0]};
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int act_pick, h, len;
        i_rst_n = 0;
        push = 0;
        i_item = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: unknown handles, empty reads, length limits and wrong ends.
        send_op(mcpf_pkg::ACT_WRITE, 255, 8'hff, 1);
        send_op(mcpf_pkg::ACT_READ, 0, 0, 64);
        send_op(mcpf_pkg::ACT_CLOSE, 100, 0, 1);
        send_op(mcpf_pkg::ACT_CREATE, 0, 0, 1);
        send_op(mcpf_pkg::ACT_READ, 100, 0, 1);
        send_op(mcpf_pkg::ACT_WRITE, 101, 8'h00, 1);
        send_op(mcpf_pkg::ACT_WRITE, 101, 8'hff, 1);
        send_op(mcpf_pkg::ACT_WRITE, 101, 8'h5a, 1);
        send_op(mcpf_pkg::ACT_READ, 100, 0, 0);
        send_op(mcpf_pkg::ACT_READ, 100, 0, 127);
        send_op(mcpf_pkg::ACT_WRITE, 100, 8'h11, 1);
        send_op(mcpf_pkg::ACT_READ, 101, 0, 4);

        // Long bursts: a read cut to the burst limit, then one cut to the fill level.
        no_gaps = 1;
        for (int i = 0; i < 70; i++)
            send_op(mcpf_pkg::ACT_WRITE, 101, $urandom_range(0, 255), 1);
        send_op(mcpf_pkg::ACT_READ, 100, 0, 100);
        send_op(mcpf_pkg::ACT_READ, 100, 0, 64);
        no_gaps = 0;

        // Closed ends: end of data, an unknown handle, and creates until no slot is left.
        send_op(mcpf_pkg::ACT_CLOSE, 101, 0, 1);
        send_op(mcpf_pkg::ACT_READ, 100, 0, 8);
        send_op(mcpf_pkg::ACT_CREATE, 0, 0, 1);
        send_op(mcpf_pkg::ACT_CLOSE, 102, 0, 1);
        send_op(mcpf_pkg::ACT_WRITE, 103, 8'h42, 1);
        for (int i = 0; i < 16; i++) send_op(mcpf_pkg::ACT_CREATE, 0, 0, 1);
        send_op(mcpf_pkg::ACT_CLOSE, 100, 0, 1);

        // Random part: mostly live handles, some noise over the whole range.
        for (int i = 0; i < 120; i++) begin
            if (i == 40) hold_results = 1;
            if (i == 80) begin
                wait_drained();
            end
            act_pick = $urandom_range(0, 99);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(98, 133);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(1, 64);
            if (act_pick < 10)
                send_op(mcpf_pkg::ACT_CREATE, h, $urandom_range(0, 255), len);
            else if (act_pick < 55)
                send_op(mcpf_pkg::ACT_WRITE, h, $urandom_range(0, 255), len);
            else if (act_pick < 85)
                send_op(mcpf_pkg::ACT_READ, h, $urandom_range(0, 255), len);
            else
                send_op(mcpf_pkg::ACT_CLOSE, h, $urandom_range(0, 255), len);
        end

        wait_drained();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
